// ----- rtl/hpc_pkg.sv -----
package hpc_pkg;

  localparam int CoordWidth = 32;
  localparam int MinPolyVerts = 3;
  localparam int DivWidth = 2 * CoordWidth + 2;
  localparam int QuoWidth = 51;
  localparam int CntWidth = $clog2(DivWidth + 1);

  typedef enum logic [1:0] {
    REG_CLIP_AXIS = 2'd0,
    REG_KEEP_SIDE = 2'd1,
    REG_CLIP_BOUND = 2'd2,
    REG_CLOSE_POLYGON = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] point_x;
    logic signed [CoordWidth-1:0] point_y;
    logic starts_gap;
    logic shape_end;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] out_x;
    logic signed [CoordWidth-1:0] out_y;
    logic out_gap;
    logic run_last;
    logic shape_done;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    logic gap;
  } vtx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HELD,
    ST_XSETUP,
    ST_XMUL,
    ST_XDIV,
    ST_XEMIT,
    ST_SELF,
    ST_CSETUP,
    ST_CMUL,
    ST_CDIV,
    ST_CEMIT,
    ST_FINISH,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic setup_from_prev;
    logic setup_close;
    logic mul_go;
    logic div_start;
    logic div_step;
    logic push_held;
    logic push_cross_enter;
    logic push_cross_leave;
    logic push_self;
    logic push_close;
    logic mark_pending_gap;
    logic finish;
    logic emit_last;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    logic in_ins;
    logic prev_ins;
    logic first_ins;
    logic held_valid;
    logic [1:0] vcount;
    logic close_en;
    logic end_flag;
    logic delta_zero;
    logic div_done;
    logic pend_valid;
  } status_t;

endpackage

// ----- rtl/half_plane_polyline_clipper.sv -----
// Channel  | Handshake            | Payload
// cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
// in       | in_valid/in_stall    | in_item (point_x, point_y, starts_gap, shape_end)
// out      | out_valid/out_stall  | out_item (out_x, out_y, out_gap, run_last, shape_done)
// Each vertex passes through accept, held push, own vertex and finish.
// Each crossing, the closing one included, adds setup, product, 66 restoring
// divider steps with a done check, and emit; a zero delta skips the divider steps.
// A shape end with a result left adds the output state.
// Reset is synchronous on rst and clears all control state.
// A stalled output holds the controller in place; the input stays stalled.
module half_plane_polyline_clipper import hpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [CoordWidth-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  in_item_t in_item,
  output logic out_valid,
  input  logic out_stall,
  output out_item_t out_item
);

  cmd_t cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  hpc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .status, .cmd
  );

  hpc_dp u_dp (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data, .in_item, .out_item,
    .cmd, .status
  );

endmodule

// ----- rtl/hpc_ctrl.sv -----
module hpc_ctrl import hpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  status_t status,
  output cmd_t cmd
);

  state_t state, state_next;
  logic have_cross, have_close;

  // Pending result holds one output at a time; the controller pushes results
  // into it and waits for the output register to drain.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign have_cross = (status.vcount != 2'd0) && (status.in_ins != status.prev_ins);
  assign have_close = status.end_flag && status.close_en &&
                      (status.vcount == 2'(MinPolyVerts)) &&
                      (status.first_ins != status.in_ins);

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = ST_HELD;
        end
      end
      ST_HELD: begin
        if (status.held_valid) cmd.push_held = 1'b1;
        state_next = have_cross ? ST_XSETUP : ST_SELF;
      end
      ST_XSETUP: begin
        cmd.setup_from_prev = 1'b1;
        state_next = ST_XMUL;
      end
      ST_XMUL: begin
        cmd.mul_go = 1'b1;
        cmd.div_start = 1'b1;
        state_next = ST_XDIV;
      end
      ST_XDIV: begin
        if (status.delta_zero || status.div_done) state_next = ST_XEMIT;
        else cmd.div_step = 1'b1;
      end
      ST_XEMIT: begin
        if (status.in_ins) cmd.push_cross_enter = 1'b1;
        else cmd.push_cross_leave = 1'b1;
        state_next = ST_SELF;
      end
      ST_SELF: begin
        if (status.in_ins) cmd.push_self = 1'b1;
        state_next = have_close ? ST_CSETUP : ST_FINISH;
      end
      ST_CSETUP: begin
        cmd.setup_close = 1'b1;
        cmd.mark_pending_gap = 1'b1;
        state_next = ST_CMUL;
      end
      ST_CMUL: begin
        cmd.mul_go = 1'b1;
        cmd.div_start = 1'b1;
        state_next = ST_CDIV;
      end
      ST_CDIV: begin
        if (status.delta_zero || status.div_done) state_next = ST_CEMIT;
        else cmd.div_step = 1'b1;
      end
      ST_CEMIT: begin
        cmd.push_close = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        if (status.pend_valid && status.end_flag) state_next = ST_OUT;
        else state_next = ST_IDLE;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.emit_last = 1'b1;
        cmd.emit_done = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    // A push while a pending result exists first sends the pending one out.
    // Away from a shape end, the last push of a request leaves the one before
    // it as the final result of that request; the last one itself is held.
    if ((cmd.push_held || cmd.push_cross_enter || cmd.push_cross_leave ||
         cmd.push_self || cmd.push_close) && status.pend_valid) begin
      out_valid = 1'b1;
      cmd.emit_last = !status.end_flag && (cmd.push_self || cmd.push_cross_leave);
      if (out_stall) begin
        cmd.push_held = 1'b0;
        cmd.push_cross_enter = 1'b0;
        cmd.push_cross_leave = 1'b0;
        cmd.push_self = 1'b0;
        cmd.push_close = 1'b0;
        cmd.mark_pending_gap = 1'b0;
        state_next = state;
      end
    end
    if (state == ST_CSETUP && status.pend_valid) out_valid = 1'b0;
  end

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> state == ST_IDLE) else $error("input taken outside idle");
  a_out_in_excl: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall)) else $error("output during input accept");
  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_XDIV && status.div_done) |=> state == ST_XEMIT)
    else $error("divider finish not followed");

endmodule

// ----- rtl/hpc_dp.sv -----
module hpc_dp import hpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [CoordWidth-1:0] cfg_data,
  input  in_item_t in_item,
  output out_item_t out_item,
  input  cmd_t cmd,
  output status_t status
);

  logic clip_axis, keep_side, close_polygon;
  logic signed [CoordWidth-1:0] clip_bound;

  in_item_t cur;
  logic cur_ins;
  logic signed [CoordWidth-1:0] prev_x, prev_y, first_x, first_y;
  logic prev_gap, prev_inside, first_inside;
  logic [1:0] vertex_count;
  vtx_t held_vertex;
  logic held_valid;

  vtx_t pend;
  logic pend_valid;

  // Interpolation operands.
  logic signed [CoordWidth-1:0] fa, fo, ta, to_o;
  logic signed [CoordWidth:0] num_d, oth_d, den_d;
  logic [CoordWidth-1:0] num_mag, oth_mag;
  logic neg;
  logic [2*CoordWidth-1:0] prod;
  logic [CoordWidth:0] dv;
  logic [DivWidth-1:0] dividend;
  logic [CoordWidth+1:0] rem;
  logic [QuoWidth-1:0] q;
  logic big;
  logic [CntWidth-1:0] cnt;
  logic delta_zero;

  logic signed [CoordWidth-1:0] in_c;
  logic in_ins_w;
  vtx_t cross_v;
  logic signed [CoordWidth+QuoWidth:0] sum;
  logic signed [CoordWidth-1:0] sat_v;
  logic [CoordWidth+1:0] rem_sh, rem_sub;

  localparam logic signed [CoordWidth+QuoWidth:0] Hi =
    (CoordWidth+QuoWidth+1)'((64'sd1 <<< (CoordWidth-1)) - 1);
  localparam logic signed [CoordWidth+QuoWidth:0] Lo = -Hi - 1;
  localparam logic [QuoWidth-1:0] QuoCap = {1'b1, {(QuoWidth-1){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_axis <= 1'b0;
      keep_side <= 1'b0;
      clip_bound <= '0;
      close_polygon <= 1'b0;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_CLIP_AXIS: clip_axis <= cfg_data[0];
        REG_KEEP_SIDE: keep_side <= cfg_data[0];
        REG_CLIP_BOUND: clip_bound <= cfg_data;
        REG_CLOSE_POLYGON: close_polygon <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_c = clip_axis ? in_item.point_y : in_item.point_x;
  assign in_ins_w = keep_side ? (in_c <= clip_bound) : (in_c >= clip_bound);

  // Crossing point assembled from the divider result.
  // A quotient above the cap only comes from stale sides and is clamped.
  always_comb begin
    logic signed [QuoWidth:0] qs;
    logic [QuoWidth-1:0] qc;
    qc = (big || (q[QuoWidth-1] && (q[QuoWidth-2:0] != '0))) ? QuoCap : q;
    qs = neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    sum = (CoordWidth+QuoWidth+1)'(fo) + (CoordWidth+QuoWidth+1)'(qs);
    if (sum > Hi) sat_v = CoordWidth'(Hi);
    else if (sum < Lo) sat_v = CoordWidth'(Lo);
    else sat_v = CoordWidth'(sum);
    cross_v.gap = 1'b0;
    if (delta_zero) begin
      cross_v.x = clip_axis ? to_o : ta;
      cross_v.y = clip_axis ? ta : to_o;
    end else begin
      cross_v.x = clip_axis ? sat_v : clip_bound;
      cross_v.y = clip_axis ? clip_bound : sat_v;
    end
  end

  assign rem_sh = {rem[CoordWidth:0], dividend[DivWidth-1]};
  assign rem_sub = rem_sh - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0; prev_y <= '0; prev_gap <= 1'b0; prev_inside <= 1'b0;
      first_x <= '0; first_y <= '0; first_inside <= 1'b0;
      vertex_count <= '0;
      held_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        cur <= in_item;
        cur_ins <= in_ins_w;
      end
      if (cmd.setup_from_prev) begin
        fa <= clip_axis ? prev_y : prev_x;
        fo <= clip_axis ? prev_x : prev_y;
        ta <= clip_axis ? cur.point_y : cur.point_x;
        to_o <= clip_axis ? cur.point_x : cur.point_y;
      end
      if (cmd.setup_close) begin
        fa <= clip_axis ? cur.point_y : cur.point_x;
        fo <= clip_axis ? cur.point_x : cur.point_y;
        ta <= clip_axis ? first_y : first_x;
        to_o <= clip_axis ? first_x : first_y;
      end
      if (cmd.mul_go) begin
        rem <= '0;
        q <= '0;
        big <= 1'b0;
        cnt <= '0;
      end
      if (cmd.div_step) begin
        if (!rem_sub[CoordWidth+1]) rem <= rem_sub;
        else rem <= rem_sh;
        if (q[QuoWidth-1]) big <= 1'b1;
        q <= {q[QuoWidth-2:0], !rem_sub[CoordWidth+1]};
        cnt <= cnt + 1'b1;
      end
      if (pend_valid && !(cmd.mark_pending_gap) &&
          (cmd.push_held || cmd.push_cross_enter || cmd.push_cross_leave ||
           cmd.push_self || cmd.push_close)) pend_valid <= 1'b0;
      if (cmd.push_held) begin
        pend <= held_vertex; pend_valid <= 1'b1;
      end
      if (cmd.push_cross_enter || cmd.push_cross_leave) begin
        pend <= '{x: cross_v.x, y: cross_v.y,
                  gap: cmd.push_cross_enter ? prev_gap : 1'b1};
        pend_valid <= 1'b1;
      end
      if (cmd.push_self) begin
        pend <= '{x: cur.point_x, y: cur.point_y, gap: cur.starts_gap};
        pend_valid <= 1'b1;
      end
      if (cmd.mark_pending_gap) pend.gap <= 1'b1;
      if (cmd.push_close) begin
        pend <= '{x: cross_v.x, y: cross_v.y, gap: 1'b1};
        pend_valid <= 1'b1;
      end
      if (cmd.finish) begin
        if (vertex_count == 2'd0) begin
          first_x <= cur.point_x; first_y <= cur.point_y; first_inside <= cur_ins;
        end
        prev_x <= cur.point_x; prev_y <= cur.point_y;
        prev_gap <= cur.starts_gap; prev_inside <= cur_ins;
        if (cur.shape_end) begin
          vertex_count <= '0;
          held_valid <= 1'b0;
        end else begin
          if (vertex_count != 2'(MinPolyVerts)) vertex_count <= vertex_count + 1'b1;
          if (pend_valid) begin
            held_vertex <= pend;
            held_valid <= 1'b1;
            pend_valid <= 1'b0;
          end else held_valid <= 1'b0;
        end
      end
      if (cmd.emit_done) pend_valid <= 1'b0;
    end
  end

  // Operand preparation; the product is loaded as the dividend when the
  // divider starts.
  assign num_d = (CoordWidth+1)'(clip_bound) - (CoordWidth+1)'(fa);
  assign oth_d = (CoordWidth+1)'(to_o) - (CoordWidth+1)'(fo);
  assign den_d = (CoordWidth+1)'(ta) - (CoordWidth+1)'(fa);
  assign delta_zero = (den_d == '0);
  assign num_mag = CoordWidth'(num_d[CoordWidth] ? -num_d : num_d);
  assign oth_mag = CoordWidth'(oth_d[CoordWidth] ? -oth_d : oth_d);
  assign prod = num_mag * oth_mag;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg <= (num_d[CoordWidth] ^ oth_d[CoordWidth]) ^ den_d[CoordWidth];
      dv <= {1'b0, CoordWidth'(den_d[CoordWidth] ? -den_d : den_d)};
      dividend <= {2'b00, prod};
    end else if (cmd.div_step) begin
      dividend <= {dividend[DivWidth-2:0], 1'b0};
    end
  end

  always_comb begin
    status.in_ins = cur_ins;
    status.prev_ins = prev_inside;
    status.first_ins = first_inside;
    status.held_valid = held_valid;
    status.vcount = (vertex_count == 2'(MinPolyVerts)) ? vertex_count :
                    vertex_count + 1'b1;
    status.close_en = close_polygon;
    status.end_flag = cur.shape_end;
    status.delta_zero = delta_zero;
    status.div_done = (cnt == CntWidth'(DivWidth));
    status.pend_valid = pend_valid;
    if (vertex_count == 2'd0) status.vcount = 2'd0;
  end

  always_comb begin
    out_item.out_x = pend.x;
    out_item.out_y = pend.y;
    out_item.out_gap = pend.gap;
    out_item.run_last = cmd.emit_last;
    out_item.shape_done = cmd.emit_done;
  end

endmodule
